### rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared widths, command and status codes, datapath operation codes and the
// control/status structs that join the sieve controller and datapath.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int SIEVE_BITS_DEF = 65536;

	localparam int LIMIT_W  = 17;
	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 16;
	localparam int ANSWER_W = 16;
	localparam int STATUS_W = 2;

	localparam int LIMIT_RESET = 65536;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] sts_t;
	typedef logic [3:0]          op_t;

	localparam cmd_t CMD_BUILD = 2'd0;
	localparam cmd_t CMD_TEST  = 2'd1;
	localparam cmd_t CMD_NTH   = 2'd2;

	localparam sts_t STS_OK       = 2'd0;
	localparam sts_t STS_NOTFOUND = 2'd1;
	localparam sts_t STS_NOTBUILT = 2'd2;

	// datapath operations, one per cycle
	localparam op_t OP_NONE      = 4'd0;
	localparam op_t OP_LOAD      = 4'd1;
	localparam op_t OP_FILL      = 4'd2;
	localparam op_t OP_J_READ    = 4'd3;
	localparam op_t OP_K_INIT    = 4'd4;
	localparam op_t OP_STRIKE    = 4'd5;
	localparam op_t OP_J_NEXT    = 4'd6;
	localparam op_t OP_TEST_READ = 4'd7;
	localparam op_t OP_TEST_RES  = 4'd8;
	localparam op_t OP_NTH_WALK  = 4'd9;
	localparam op_t OP_EMIT      = 4'd10;

	typedef struct packed {
		op_t  op;
		sts_t sts;
	} ctrl_t;

	typedef struct packed {
		logic k_end;
		logic sq_end;
		logic j_marked;
		logic nth_hit;
		logic nth_end;
	} stat_t;

endpackage

### rtl/pse_if.sv
// ----------------------------------------------------------------------------
// pse_if
// Valid/ready channels for sieve requests and results.
// ----------------------------------------------------------------------------
interface pse_req_if;
	logic                       valid;
	logic                       ready;
	logic [pse_pkg::CMD_W-1:0]   command;
	logic [pse_pkg::VALUE_W-1:0] value;

	modport source (output valid, output command, output value, input ready);
	modport sink   (input valid, input command, input value, output ready);
endinterface

interface pse_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pse_pkg::ANSWER_W-1:0] answer;
	logic [pse_pkg::STATUS_W-1:0] status;

	modport source (output valid, output answer, output status, input ready);
	modport sink   (input valid, input answer, input status, output ready);
endinterface

### rtl/pse_dp.sv
// ----------------------------------------------------------------------------
// pse_dp
// Sieve datapath: composite bit store, limit register, fill/strike/walk
// counters, result and output payload registers.
// ----------------------------------------------------------------------------
module pse_dp #(
	parameter int SIEVE_BITS = pse_pkg::SIEVE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pse_pkg::ctrl_t                ctrl,
	output pse_pkg::stat_t                stat,
	input  logic [pse_pkg::VALUE_W-1:0]   req_value,
	input  logic                          cfg_we,
	input  logic [pse_pkg::LIMIT_W-1:0]   cfg_wdata,
	output logic [pse_pkg::ANSWER_W-1:0]  answer,
	output logic [pse_pkg::STATUS_W-1:0]  status
);

	localparam int AW = $clog2(SIEVE_BITS);
	localparam int LW = AW + 1;
	localparam int CW = (LW > pse_pkg::LIMIT_W) ? LW : pse_pkg::LIMIT_W;
	localparam int LIM_RST_I =
		(pse_pkg::LIMIT_RESET > SIEVE_BITS) ? SIEVE_BITS : pse_pkg::LIMIT_RESET;
	localparam logic [CW-1:0] LIM_RST = CW'(LIM_RST_I);
	localparam logic [CW-1:0] LIM_CAP = CW'(SIEVE_BITS);

	logic mem [SIEVE_BITS];

	logic [CW-1:0]                  lim_q;
	logic [pse_pkg::VALUE_W-1:0]    val_q;
	logic [CW:0]                    k_q;
	logic [CW:0]                    step_q;
	logic [CW-1:0]                  j_q;
	logic [CW+1:0]                  sq_q;
	logic [CW:0]                    p_q;
	logic [CW:0]                    p_s1;
	logic                           vld_s1;
	logic                           tog_q;
	logic [pse_pkg::VALUE_W-1:0]    cnt_q;
	logic                           rd_q;
	logic [pse_pkg::ANSWER_W-1:0]   ans_q;
	logic [pse_pkg::STATUS_W-1:0]   sts_q;
	logic [pse_pkg::ANSWER_W-1:0]   answer_q;
	logic [pse_pkg::STATUS_W-1:0]   status_q;

	logic [CW-1:0]   cfg_ext;
	logic [CW-1:0]   val_ext;
	logic [CW:0]     lim_k;
	logic            p_in;
	logic [CW:0]     p_nxt;
	logic            cand_prime;
	logic            fill_bit;
	logic            mem_we;
	logic [AW-1:0]   wa;
	logic            wd;
	logic            mem_re;
	logic [AW-1:0]   ra;

	assign cfg_ext = CW'(cfg_wdata);
	assign val_ext = CW'(val_q);
	assign lim_k   = (CW+1)'(lim_q);
	assign p_in    = p_q < lim_k;

	// walk order 2, 3, then alternating +2 / +4 over 6k-1, 6k+1
	always_comb begin
		if (p_q == (CW+1)'(2)) begin
			p_nxt = (CW+1)'(3);
		end else if (p_q == (CW+1)'(3)) begin
			p_nxt = (CW+1)'(5);
		end else if (tog_q) begin
			p_nxt = p_q + (CW+1)'(4);
		end else begin
			p_nxt = p_q + (CW+1)'(2);
		end
	end

	assign cand_prime = vld_s1 && !rd_q;

	assign stat.k_end    = k_q >= lim_k;
	assign stat.sq_end   = sq_q >= (CW+2)'(lim_q);
	assign stat.j_marked = rd_q;
	assign stat.nth_hit  = cand_prime &&
		((17'(cnt_q) + 17'd1) == 17'(val_q));
	assign stat.nth_end  = !vld_s1 && !p_in;

	// initial marks: 0, 1 and even numbers from 4 upward
	assign fill_bit = (k_q < (CW+1)'(2)) || (!k_q[0] && k_q >= (CW+1)'(4));

	always_comb begin
		mem_we = 1'b0;
		wd     = 1'b1;
		mem_re = 1'b0;
		ra     = j_q[AW-1:0];
		case (ctrl.op)
			pse_pkg::OP_FILL: begin
				mem_we = 1'b1;
				wd     = fill_bit;
			end
			pse_pkg::OP_STRIKE: begin
				mem_we = 1'b1;
			end
			pse_pkg::OP_J_READ: begin
				mem_re = 1'b1;
			end
			pse_pkg::OP_TEST_READ: begin
				mem_re = 1'b1;
				ra     = val_ext[AW-1:0];
			end
			pse_pkg::OP_NTH_WALK: begin
				mem_re = p_in;
				ra     = p_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	assign wa = k_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wa] <= wd;
		end
		if (mem_re) begin
			rd_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= LIM_RST;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				lim_q <= (cfg_ext > LIM_CAP) ? LIM_CAP : cfg_ext;
			end
			if (ctrl.op == pse_pkg::OP_LOAD) begin
				vld_s1 <= 1'b0;
			end else if (ctrl.op == pse_pkg::OP_NTH_WALK) begin
				vld_s1 <= p_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			pse_pkg::OP_LOAD: begin
				val_q <= req_value;
				k_q   <= '0;
				j_q   <= CW'(3);
				sq_q  <= (CW+2)'(9);
				p_q   <= (CW+1)'(2);
				tog_q <= 1'b0;
				cnt_q <= '0;
				ans_q <= '0;
				sts_q <= ctrl.sts;
			end
			pse_pkg::OP_FILL: begin
				k_q <= k_q + (CW+1)'(1);
			end
			pse_pkg::OP_K_INIT: begin
				k_q    <= sq_q[CW:0];
				step_q <= {j_q, 1'b0};
			end
			pse_pkg::OP_STRIKE: begin
				k_q <= k_q + step_q;
			end
			pse_pkg::OP_J_NEXT: begin
				// (j+2)^2 = j^2 + 4j + 4
				sq_q <= sq_q + {j_q, 2'b00} + (CW+2)'(4);
				j_q  <= j_q + CW'(2);
			end
			pse_pkg::OP_TEST_RES: begin
				ans_q <= pse_pkg::ANSWER_W'((val_ext < lim_q) && !rd_q);
				sts_q <= pse_pkg::STS_OK;
			end
			pse_pkg::OP_NTH_WALK: begin
				if (p_in) begin
					p_s1  <= p_q;
					p_q   <= p_nxt;
					if (p_q > (CW+1)'(3)) begin
						tog_q <= !tog_q;
					end
				end
				if (cand_prime) begin
					cnt_q <= cnt_q + pse_pkg::VALUE_W'(1);
				end
				if (stat.nth_hit) begin
					if (p_s1 > (CW+1)'(16'hFFFF)) begin
						ans_q <= '0;
						sts_q <= pse_pkg::STS_NOTFOUND;
					end else begin
						ans_q <= p_s1[pse_pkg::ANSWER_W-1:0];
						sts_q <= pse_pkg::STS_OK;
					end
				end else if (stat.nth_end) begin
					ans_q <= '0;
					sts_q <= pse_pkg::STS_NOTFOUND;
				end
			end
			pse_pkg::OP_EMIT: begin
				answer_q <= ans_q;
				status_q <= sts_q;
			end
			default: begin
			end
		endcase
	end

	assign answer = answer_q;
	assign status = status_q;

endmodule

### rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Sieve controller: request decode, build/test/nth sequencing, built flag
// and result valid.
// ----------------------------------------------------------------------------
module pse_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic [pse_pkg::CMD_W-1:0] req_command,
	input  logic                      value_zero,
	input  logic                      cfg_we,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output pse_pkg::ctrl_t            ctrl,
	input  pse_pkg::stat_t            stat
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FILL   = 4'd1;
	localparam logic [3:0] ST_JCHK   = 4'd2;
	localparam logic [3:0] ST_JTEST  = 4'd3;
	localparam logic [3:0] ST_STRIKE = 4'd4;
	localparam logic [3:0] ST_TEST   = 4'd5;
	localparam logic [3:0] ST_TRES   = 4'd6;
	localparam logic [3:0] ST_NTH    = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       built_q;
	logic       out_valid_q;
	logic       accept;
	logic       emit;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign emit      = (state_q == ST_DONE) && (!out_valid_q || rsp_ready);

	always_comb begin
		state_d  = state_q;
		ctrl.op  = pse_pkg::OP_NONE;
		ctrl.sts = pse_pkg::STS_OK;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctrl.op = pse_pkg::OP_LOAD;
					case (req_command)
						pse_pkg::CMD_BUILD: begin
							state_d = ST_FILL;
						end
						pse_pkg::CMD_TEST: begin
							if (built_q) begin
								state_d = ST_TEST;
							end else begin
								ctrl.sts = pse_pkg::STS_NOTBUILT;
								state_d  = ST_DONE;
							end
						end
						pse_pkg::CMD_NTH: begin
							if (!built_q) begin
								ctrl.sts = pse_pkg::STS_NOTBUILT;
								state_d  = ST_DONE;
							end else if (value_zero) begin
								ctrl.sts = pse_pkg::STS_NOTFOUND;
								state_d  = ST_DONE;
							end else begin
								state_d = ST_NTH;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_FILL: begin
				if (stat.k_end) begin
					state_d = ST_JCHK;
				end else begin
					ctrl.op = pse_pkg::OP_FILL;
				end
			end
			ST_JCHK: begin
				if (stat.sq_end) begin
					state_d = ST_DONE;
				end else begin
					ctrl.op = pse_pkg::OP_J_READ;
					state_d = ST_JTEST;
				end
			end
			ST_JTEST: begin
				// composite j has no multiples left to strike
				if (stat.j_marked) begin
					ctrl.op = pse_pkg::OP_J_NEXT;
					state_d = ST_JCHK;
				end else begin
					ctrl.op = pse_pkg::OP_K_INIT;
					state_d = ST_STRIKE;
				end
			end
			ST_STRIKE: begin
				if (stat.k_end) begin
					ctrl.op = pse_pkg::OP_J_NEXT;
					state_d = ST_JCHK;
				end else begin
					ctrl.op = pse_pkg::OP_STRIKE;
				end
			end
			ST_TEST: begin
				ctrl.op = pse_pkg::OP_TEST_READ;
				state_d = ST_TRES;
			end
			ST_TRES: begin
				ctrl.op = pse_pkg::OP_TEST_RES;
				state_d = ST_DONE;
			end
			ST_NTH: begin
				ctrl.op = pse_pkg::OP_NTH_WALK;
				if (stat.nth_hit || stat.nth_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (emit) begin
					ctrl.op = pse_pkg::OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				built_q <= 1'b0;
			end else if (state_q == ST_JCHK && stat.sq_end) begin
				built_q <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

### rtl/prime_sieve_engine_core.sv
// ----------------------------------------------------------------------------
// prime_sieve_engine_core
// Sieve of Eratosthenes over a one-bit-per-number composite store.
//
// req carries a command and a value; rsp returns one answer and status per
// request, through an output register so a new request is taken while an
// earlier result still waits. cfg_we / cfg_wdata write the sieve limit,
// which is capped at SIEVE_BITS and forces a rebuild.
// Steps per request, L being the effective limit:
//   build  a fill of every entry below L, then for each odd j whose
//          square is below L a read of j and, if j is unmarked, one
//          strike per odd multiple from j squared, all set by the single
//          write port of the bit store
//   test   a read of the value, then the result
//   nth    a walk over the candidates below L, one candidate read per cycle
// Reset clears the built flag and sets the limit to 65536; the bit store is
// not cleared, as build rewrites every entry below the limit.
// A stalled receiver holds the finished result; the next request is still
// worked on, and its result waits until the register frees up.
// ----------------------------------------------------------------------------
module prime_sieve_engine_core #(
	parameter int SIEVE_BITS = pse_pkg::SIEVE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	pse_req_if.sink                     req,
	pse_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [pse_pkg::LIMIT_W-1:0] cfg_wdata
);

	pse_pkg::ctrl_t ctrl;
	pse_pkg::stat_t stat;
	logic           req_ready;
	logic           rsp_valid;
	logic [pse_pkg::ANSWER_W-1:0] answer;
	logic [pse_pkg::STATUS_W-1:0] status;

	pse_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req_ready),
		.req_command (req.command),
		.value_zero  (req.value == '0),
		.cfg_we      (cfg_we),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp.ready),
		.ctrl        (ctrl),
		.stat        (stat)
	);

	pse_dp #(
		.SIEVE_BITS (SIEVE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.stat        (stat),
		.req_value   (req.value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.answer      (answer),
		.status      (status)
	);

	assign req.ready  = req_ready;
	assign rsp.valid  = rsp_valid;
	assign rsp.answer = answer;
	assign rsp.status = status;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for prime_sieve_engine_core. A behavioural sieve in the
// bench predicts the answer and status of every request. Each result taken
// from the core is compared with the oldest prediction. The directed tests
// cover queries before a build, the full-range sieve and limit edges,
// including saturation. Random phases then vary the limit, with idle and
// stall bursts on both channels, except in a closing run of phases.
// ----------------------------------------------------------------------------
module tb_top;

	typedef logic [pse_pkg::VALUE_W-1:0] value_t;

	localparam pse_pkg::cmd_t CMD_NOP     = 2'd3;
	localparam int            SIEVE_N     = pse_pkg::SIEVE_BITS_DEF;
	localparam longint        CYCLE_LIMIT = 6_000_000;
	localparam int            HOLD_CYCLES = 4;

	typedef struct {
		pse_pkg::cmd_t                cmd;
		value_t                       val;
		logic [pse_pkg::ANSWER_W-1:0] answer;
		pse_pkg::sts_t                status;
	} sieve_result_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [pse_pkg::LIMIT_W-1:0] cfg_wdata;

	pse_req_if req();
	pse_rsp_if rsp();

	prime_sieve_engine_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the core's sieve
	bit          composite_map [SIEVE_N];
	bit          sieve_ready;
	int unsigned limit_reg;

	sieve_result_t pending_answers[$];
	int     err_count;
	int     req_count;
	int     build_count;
	int     limit_count;
	longint cycle_count;
	bit     gaps_en;
	bit     stall_en;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results outstanding",
				cycle_count, pending_answers.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic int unsigned eff_limit();
		return (limit_reg > SIEVE_N) ? SIEVE_N : limit_reg;
	endfunction

	function automatic bit prime_below(int unsigned n, int unsigned lim);
		return (n < lim) && !composite_map[n];
	endfunction

	function automatic void rebuild_sieve();
		int unsigned lim;
		int unsigned j;
		int unsigned k;
		lim = eff_limit();
		foreach (composite_map[i]) composite_map[i] = 1'b0;
		if (lim > 0) composite_map[0] = 1'b1;
		if (lim > 1) composite_map[1] = 1'b1;
		for (k = 4; k < lim; k += 2) composite_map[k] = 1'b1;
		for (j = 3; j * j < lim; j += 2) begin
			if (!composite_map[j]) begin
				for (k = j * j; k < lim; k += 2 * j) composite_map[k] = 1'b1;
			end
		end
		sieve_ready = 1'b1;
	endfunction

	// primes in the order 2, 3, then 6k-1 and 6k+1; 0 when the limit is hit
	function automatic int unsigned prime_by_index(int unsigned n);
		int unsigned lim;
		int unsigned cnt;
		int unsigned p;
		lim = eff_limit();
		cnt = 0;
		if (prime_below(2, lim)) begin
			cnt++;
			if (cnt == n) return 2;
		end
		if (prime_below(3, lim)) begin
			cnt++;
			if (cnt == n) return 3;
		end
		for (p = 5; p < lim; p += 6) begin
			if (prime_below(p, lim)) begin
				cnt++;
				if (cnt == n) return p;
			end
			if (prime_below(p + 2, lim)) begin
				cnt++;
				if (cnt == n) return p + 2;
			end
		end
		return 0;
	endfunction

	function automatic sieve_result_t predict_result(pse_pkg::cmd_t c, value_t v);
		sieve_result_t r;
		int unsigned   p;
		r.cmd    = c;
		r.val    = v;
		r.answer = '0;
		r.status = pse_pkg::STS_OK;
		case (c)
			pse_pkg::CMD_BUILD: begin
				rebuild_sieve();
			end
			pse_pkg::CMD_TEST, pse_pkg::CMD_NTH: begin
				if (!sieve_ready) begin
					r.status = pse_pkg::STS_NOTBUILT;
				end else if (c == pse_pkg::CMD_TEST) begin
					r.answer = prime_below(v, eff_limit()) ? 16'd1 : 16'd0;
				end else if (v == 0) begin
					r.status = pse_pkg::STS_NOTFOUND;
				end else begin
					p = prime_by_index(v);
					if (p == 0 || p > 16'hFFFF) r.status = pse_pkg::STS_NOTFOUND;
					else r.answer = p[pse_pkg::ANSWER_W-1:0];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string what);
		err_count++;
		$display("mismatch @%0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		sieve_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("unexpected result answer %0d status %0d",
					rsp.answer, rsp.status));
			end else begin
				want = pending_answers.pop_front();
				if (rsp.answer !== want.answer)
					report_mismatch($sformatf("cmd %0d value %0d: answer %0d, want %0d",
						want.cmd, want.val, rsp.answer, want.answer));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("cmd %0d value %0d: status %0d, want %0d",
						want.cmd, want.val, rsp.status, want.status));
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_en && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			rsp.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- driving

	// valid stays high after acceptance so back-to-back requests need no toggle
	task automatic send_req(pse_pkg::cmd_t c, value_t v);
		if (gaps_en && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req.valid   <= 1'b1;
		req.command <= c;
		req.value   <= v;
		do @(posedge clk); while (!req.ready);
		pending_answers.push_back(predict_result(c, v));
		req_count++;
		if (c == pse_pkg::CMD_BUILD) build_count++;
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (HOLD_CYCLES) @(posedge clk);
	endtask

	// only called with the core idle
	task automatic write_limit(logic [pse_pkg::LIMIT_W-1:0] lim);
		cfg_we    <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		limit_reg   = lim;
		sieve_ready = 1'b0;
		limit_count++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_before_build();
		send_req(pse_pkg::CMD_TEST, 16'd7);
		send_req(pse_pkg::CMD_NTH, 16'd1);
		send_req(CMD_NOP, 16'hFFFF);
		wait_drained();
	endtask

	// reset limit, the whole store
	task automatic test_full_range();
		send_req(pse_pkg::CMD_BUILD, 16'd0);
		send_req(pse_pkg::CMD_TEST, 16'd0);
		send_req(pse_pkg::CMD_TEST, 16'd2);
		send_req(pse_pkg::CMD_TEST, 16'd4);
		send_req(pse_pkg::CMD_TEST, 16'd65521);
		send_req(pse_pkg::CMD_TEST, 16'hFFFF);
		send_req(pse_pkg::CMD_NTH, 16'd0);
		send_req(pse_pkg::CMD_NTH, 16'd1);
		send_req(pse_pkg::CMD_NTH, 16'd2);
		send_req(pse_pkg::CMD_NTH, 16'd6542);
		send_req(pse_pkg::CMD_NTH, 16'd6543);
		wait_drained();
	endtask

	task automatic test_limit_edges();
		write_limit(17'd16);
		send_req(pse_pkg::CMD_TEST, 16'd13);
		send_req(pse_pkg::CMD_BUILD, 16'd0);
		send_req(pse_pkg::CMD_TEST, 16'd13);
		send_req(pse_pkg::CMD_TEST, 16'd16);
		send_req(pse_pkg::CMD_NTH, 16'd6);
		send_req(pse_pkg::CMD_NTH, 16'd7);
		wait_drained();
		write_limit(17'd0);
		send_req(pse_pkg::CMD_BUILD, 16'd0);
		send_req(pse_pkg::CMD_NTH, 16'd1);
		wait_drained();
		write_limit(17'd3);
		send_req(pse_pkg::CMD_BUILD, 16'd0);
		send_req(pse_pkg::CMD_NTH, 16'd1);
		wait_drained();
		// above the store size, saturates
		write_limit(17'h1FFFF);
		send_req(pse_pkg::CMD_BUILD, 16'd0);
		send_req(pse_pkg::CMD_TEST, 16'd65521);
		send_req(pse_pkg::CMD_NTH, 16'd6542);
		wait_drained();
	endtask

	task automatic send_random_req(int unsigned lim);
		int unsigned pick;
		int unsigned sel;
		value_t      v;
		pick = $urandom_range(0, 99);
		sel  = $urandom_range(0, 9);
		if (pick < 45) begin
			v = (sel < 3) ? value_t'($urandom) : value_t'($urandom_range(0, lim + 8));
			send_req(pse_pkg::CMD_TEST, v);
		end else if (pick < 87) begin
			if (sel == 0) v = '0;
			else if (sel == 1) v = value_t'($urandom);
			else v = value_t'($urandom_range(1, lim / 6 + 2));
			send_req(pse_pkg::CMD_NTH, v);
		end else if (pick < 94) begin
			send_req(pse_pkg::CMD_BUILD, value_t'($urandom));
		end else begin
			send_req(CMD_NOP, value_t'($urandom));
		end
	endtask

	task automatic test_random_phases(int n_phases, bit with_idle);
		int unsigned lim;
		int unsigned sel;
		repeat (n_phases) begin
			wait_drained();
			gaps_en  = with_idle && ($urandom_range(0, 3) != 0);
			stall_en = with_idle && ($urandom_range(0, 3) != 0);
			// mostly small limits so builds and walks stay short
			sel = $urandom_range(0, 9);
			if (sel == 0) lim = $urandom_range(0, 15);
			else if (sel == 1) lim = $urandom_range(1025, 4096);
			else lim = $urandom_range(16, 1024);
			write_limit(lim[pse_pkg::LIMIT_W-1:0]);
			if ($urandom_range(0, 3) == 0)
				send_req(($urandom_range(0, 1) == 0) ? pse_pkg::CMD_TEST : pse_pkg::CMD_NTH,
					value_t'($urandom));
			send_req(pse_pkg::CMD_BUILD, value_t'($urandom));
			repeat (30) send_random_req(lim);
		end
		wait_drained();
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= '0;
		req.valid   <= 1'b0;
		req.command <= pse_pkg::CMD_BUILD;
		req.value   <= '0;
		gaps_en      = 1'b0;
		stall_en     = 1'b0;
		limit_reg    = pse_pkg::LIMIT_RESET;
		sieve_ready  = 1'b0;
		foreach (composite_map[i]) composite_map[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_build();
		test_full_range();
		test_limit_edges();
		test_random_phases(16, 1'b1);
		// closing stretch runs flat out
		test_random_phases(2, 1'b0);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("run covered %0d requests (%0d builds) over %0d limit writes in %0d cycles",
			req_count, build_count, limit_count, cycle_count);
		$display("%0d mismatches", err_count);
		if (err_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
